>>> rtl/lif_pkg.sv
// ----------------------------------------------------------------------------
// lif_pkg: shared types and constants for the lif neuron layer step unit
// word formats of the item, result and configuration channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lif_pkg;

  // field widths
  localparam int IDX_W   = 13;
  localparam int CUR_W   = 16;
  localparam int DECAY_W = 16;
  localparam int THR_W   = 23;
  localparam int MEM_W   = 24;
  localparam int CFG_W   = 23;

  // defaults
  localparam int NEURON_COUNT_DEF = 8192;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd58982;
  localparam logic [THR_W-1:0]   THR_RESET   = 23'd256;

  typedef enum logic {
    MODE_INTEGRATE = 1'b0,
    MODE_CLEAR     = 1'b1
  } mode_t;

  typedef enum logic {
    REG_DECAY     = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    mode_t                    mode;
    logic [IDX_W-1:0]         neuron_index;
    logic signed [CUR_W-1:0]  current;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         neuron_tag;
    logic                     spike;
    logic signed [MEM_W-1:0]  membrane;
    logic                     saturated;
  } result_t;

endpackage

>>> rtl/lif_neuron_layer_step_unit.sv
// ----------------------------------------------------------------------------
// lif_neuron_layer_step_unit: leaky integrate-and-fire neuron layer step
// throughput: one item word per cycle while the result channel does not stall
//   and the neuron indexes differ; an item for a neuron still in flight waits
//   until that update is written
// reset: decay 58982, threshold 256; then a clearing pass zeroes the state
//   memory, no item word is taken meanwhile
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lif_neuron_layer_step_unit #(
  parameter int NEURON_COUNT = lif_pkg::NEURON_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // item channel
  input  logic                        item_valid,
  output logic                        item_ready,
  input  lif_pkg::item_t              item,
  // result channel
  output logic                        result_valid,
  input  logic                        result_ready,
  output lif_pkg::result_t            result,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  lif_pkg::cfg_reg_t           cfg_index,
  input  logic [lif_pkg::CFG_W-1:0]   cfg_data
);

  // address and compare widths follow the layer size
  localparam int ADDR_W = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
  localparam int CNT_W  = $clog2(NEURON_COUNT + 1);
  localparam int CMP_W  = (CNT_W > lif_pkg::IDX_W) ? CNT_W : lif_pkg::IDX_W;
  localparam int MW     = lif_pkg::MEM_W;
  localparam int DW     = lif_pkg::DECAY_W;
  localparam int CW     = lif_pkg::CUR_W;
  // product of signed membrane and zero-extended decay
  localparam int PROD_W = MW + DW + 1;
  // product after dropping the fraction bits of the decay
  localparam int SCL_W  = PROD_W - DW;
  localparam int SUM_W  = SCL_W + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NEURON_COUNT - 1);
  localparam logic [CMP_W-1:0]  COUNT_CMP = CMP_W'(NEURON_COUNT);
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (DW - 1);
  localparam logic signed [SUM_W-1:0]  SAT_HI =
    {{(SUM_W-MW+1){1'b0}}, {(MW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  SAT_LO =
    {{(SUM_W-MW+1){1'b1}}, {(MW-1){1'b0}}};

  // control carried along the pipeline
  typedef struct packed {
    logic                       integ;   // integrate step, else clear
    logic                       ok;      // index inside the layer
    logic [lif_pkg::IDX_W-1:0]  idx;
    logic signed [CW-1:0]       cur;
  } ctl_t;

  // configuration registers
  logic [DW-1:0]             decay_factor;
  logic [lif_pkg::THR_W-1:0] fire_threshold;

  // clearing pass after reset
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // state memory: bit MW is the raw spike, below it the membrane
  logic [MW:0] state_mem [NEURON_COUNT];
  logic [MW:0] rd_word;

  // pipeline registers
  logic                     v1, v2, v3;
  ctl_t                     c1, c2, c3;
  logic signed [PROD_W-1:0] prod2;
  logic                     spk2, spk3;
  logic signed [MW-1:0]     sum3;
  logic                     sat3;

  logic                     advance;
  logic                     hazard;
  logic                     accept;
  logic [CMP_W-1:0]         idx_ext;
  ctl_t                     c0;

  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [SUM_W-1:0]  sum_wide;
  logic signed [MW-1:0]     sum_sat;
  logic                     sat_any;

  logic                     fire;
  logic signed [MW-1:0]     mem_new;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [MW:0]              wr_word;

  // the output register frees the pipe whenever it is empty or being drained
  assign advance = !result_valid || result_ready;

  // interlock: an item for a neuron that is still being updated waits
  assign hazard = (v1 && (c1.idx == item.neuron_index)) ||
                  (v2 && (c2.idx == item.neuron_index)) ||
                  (v3 && (c3.idx == item.neuron_index));

  assign item_ready = !clearing && advance && !hazard;
  assign accept     = item_valid && item_ready;
  assign cfg_ready  = 1'b1;

  // decode the incoming word
  assign idx_ext  = CMP_W'(item.neuron_index);
  assign c0.integ = (item.mode == lif_pkg::MODE_INTEGRATE);
  assign c0.ok    = (idx_ext < COUNT_CMP);
  assign c0.idx   = item.neuron_index;
  assign c0.cur   = item.current;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor   <= lif_pkg::DECAY_RESET;
      fire_threshold <= lif_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lif_pkg::REG_DECAY:     decay_factor   <= cfg_data[DW-1:0];
        lif_pkg::REG_THRESHOLD: fire_threshold <= cfg_data[lif_pkg::THR_W-1:0];
      endcase
    end
  end

  // clearing pass, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  // stage 3 arithmetic: round half up, add current, saturate
  assign prod_rnd = prod2 + ROUND_BIAS;
  assign scaled   = prod_rnd[PROD_W-1:DW];
  assign sum_wide = $signed({scaled[SCL_W-1], scaled}) +
                    $signed({{(SUM_W-CW){c2.cur[CW-1]}}, c2.cur});

  always_comb begin
    sat_any = 1'b0;
    sum_sat = sum_wide[MW-1:0];
    if (sum_wide > SAT_HI) begin
      sum_sat = SAT_HI[MW-1:0];
      sat_any = 1'b1;
    end else if (sum_wide < SAT_LO) begin
      sum_sat = SAT_LO[MW-1:0];
      sat_any = 1'b1;
    end
  end

  // write stage: fire test and subtract reset
  assign fire    = $signed({sum3[MW-1], sum3}) >=
                   $signed({1'b0, (MW)'(fire_threshold)});
  assign mem_new = fire ? (sum3 - $signed(MW'(fire_threshold))) : sum3;

  // write port shared by the clearing pass and the write stage
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ADDR_W'(c3.idx);
    wr_word = c3.integ ? {fire, mem_new} : '0;
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_word = '0;
    end else if (advance && v3 && c3.ok) begin
      wr_en = 1'b1;
    end
  end

  // state memory, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem[wr_addr] <= wr_word;
    end
    if (advance) begin
      rd_word <= state_mem[idx_ext[ADDR_W-1:0]];
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v1           <= accept;
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      // stage 1: memory read in flight
      c1    <= c0;
      // stage 2: leak multiply
      c2    <= c1;
      prod2 <= PROD_W'($signed(rd_word[MW-1:0])) * PROD_W'($signed({1'b0, decay_factor}));
      spk2  <= rd_word[MW];
      // stage 3: rounded sum
      c3    <= c2;
      sum3  <= sum_sat;
      sat3  <= sat_any;
      spk3  <= spk2;
      // result register
      result.neuron_tag <= c3.idx;
      if (c3.ok && c3.integ) begin
        result.spike     <= spk3;
        result.membrane  <= mem_new;
        result.saturated <= sat3;
      end else begin
        result.spike     <= 1'b0;
        result.membrane  <= '0;
        result.saturated <= 1'b0;
      end
    end
  end

  // in-flight items always name distinct neurons
  a_distinct: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2) |-> (c1.idx != c2.idx))
    else $error("neuron twice in flight, stages 1 and 2");

  a_distinct_far: assert property (@(posedge clk) disable iff (rst)
    (v3 && (v1 || v2)) |-> ((!v1 || (c1.idx != c3.idx)) && (!v2 || (c2.idx != c3.idx))))
    else $error("neuron twice in flight, stage 3");

  // pipe stays empty during the clearing pass
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!v1 && !v2 && !v3 && !result_valid))
    else $error("item in flight during clearing pass");

  // clearing ends only after the last entry
  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> ($past(clr_addr) == LAST_ADDR))
    else $error("clearing pass ended early");

  // a clip always lands on a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (v3 && sat3) |-> ((sum3 == SAT_HI[MW-1:0]) || (sum3 == SAT_LO[MW-1:0])))
    else $error("saturated flag without a clipped sum");

endmodule

>>> bench/lif_neuron_layer_step_unit_tb.sv
// ----------------------------------------------------------------------------
// lif_neuron_layer_step_unit_tb: self-checking bench for the lif layer step
// drives neuron update words with random gaps and result back-pressure,
// predicts every result from its own copy of the neuron state and settings,
// and compares each result word field by field in arrival order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lif_neuron_layer_step_unit_tb;

  localparam int     NEURONS    = lif_pkg::NEURON_COUNT_DEF;
  localparam longint MEM_MAX    = (longint'(1) <<< (lif_pkg::MEM_W - 1)) - 1;
  localparam longint MEM_MIN    = -MEM_MAX - 1;
  localparam int     STALL_MAX  = 10;
  // clearing pass after reset plus generous slack for stalls and hazards
  localparam int     IDLE_LIMIT = 4 * NEURONS + 2000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_ready;
  lif_pkg::item_t            item_word = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  lif_pkg::result_t          result_word;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  lif_pkg::cfg_reg_t         cfg_index = lif_pkg::REG_DECAY;
  logic [lif_pkg::CFG_W-1:0] cfg_data = '0;

  // predictor state: neuron memories and the register settings
  logic signed [lif_pkg::MEM_W-1:0] neuron_membrane [NEURONS];
  logic                             neuron_spike    [NEURONS];
  logic [lif_pkg::DECAY_W-1:0]      decay_setting = lif_pkg::DECAY_RESET;
  logic [lif_pkg::THR_W-1:0]        thr_setting   = lif_pkg::THR_RESET;

  lif_pkg::result_t due_updates [$];   // predicted result words, oldest first
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  bit      send_quiet = 1'b0; // stretch with no sender gaps
  bit      sink_quiet = 1'b0; // stretch with no receiver stalls

  lif_neuron_layer_step_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // one neuron step: leak, add current, saturate, fire and subtract threshold
  function automatic lif_pkg::result_t integrate_neuron(input lif_pkg::item_t it);
    lif_pkg::result_t upd;
    longint  acc;
    int      n;
    upd.neuron_tag = it.neuron_index;
    upd.spike      = 1'b0;
    upd.membrane   = '0;
    upd.saturated  = 1'b0;
    n = int'(it.neuron_index);
    // out-of-range index: echo only, state untouched
    if (n >= NEURONS) return upd;
    if (it.mode == lif_pkg::MODE_CLEAR) begin
      neuron_membrane[n] = '0;
      neuron_spike[n]    = 1'b0;
      return upd;
    end
    // Q16.8 * Q0.16, round half up back to Q16.8 (shift floors)
    acc = (longint'(neuron_membrane[n]) * longint'(decay_setting) + 32768) >>> 16;
    acc = acc + longint'(it.current);
    if (acc > MEM_MAX) begin
      acc = MEM_MAX;
      upd.saturated = 1'b1;
    end else if (acc < MEM_MIN) begin
      acc = MEM_MIN;
      upd.saturated = 1'b1;
    end
    // the reported spike is the one stored on the previous step
    upd.spike = neuron_spike[n];
    if (acc >= longint'(thr_setting)) begin
      acc = acc - longint'(thr_setting);
      neuron_spike[n] = 1'b1;
    end else begin
      neuron_spike[n] = 1'b0;
    end
    neuron_membrane[n] = lif_pkg::MEM_W'(acc);
    upd.membrane = lif_pkg::MEM_W'(acc);
    return upd;
  endfunction

  function automatic lif_pkg::item_t make_item(input lif_pkg::mode_t m, input int n,
                                               input int cur);
    lif_pkg::item_t it;
    it.mode         = m;
    it.neuron_index = lif_pkg::IDX_W'(n);
    it.current      = lif_pkg::CUR_W'(cur);
    return it;
  endfunction

  // ------------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string what,
                                 input logic [lif_pkg::IDX_W-1:0] tag,
                                 input longint got, input longint want);
    $display("%0t mismatch %s neuron %0d: got %0d want %0d",
             $realtime, what, tag, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input lif_pkg::result_t got);
    lif_pkg::result_t want;
    if (due_updates.size() == 0) begin
      report_mismatch("unexpected word", got.neuron_tag, 0, 0);
      return;
    end
    want = due_updates.pop_front();
    if (got.neuron_tag !== want.neuron_tag)
      report_mismatch("neuron_tag", want.neuron_tag, got.neuron_tag, want.neuron_tag);
    if (got.spike !== want.spike)
      report_mismatch("spike", want.neuron_tag, got.spike, want.spike);
    if (got.membrane !== want.membrane)
      report_mismatch("membrane", want.neuron_tag, got.membrane, want.membrane);
    if (got.saturated !== want.saturated)
      report_mismatch("saturated", want.neuron_tag, got.saturated, want.saturated);
  endtask

  // result side: take a word, then stall a random number of cycles
  always @(posedge clk) begin : result_sink
    int unsigned hold;
    if (rst) begin
      result_ready <= 1'b0;
      hold = 0;
    end else if (result_valid && result_ready) begin
      check_result(result_word);
      if ($urandom_range(0, 31) == 0) sink_quiet = !sink_quiet;
      hold = sink_quiet ? 0 : $urandom_range(0, STALL_MAX);
      result_ready <= (hold == 0);
    end else if (hold > 0) begin
      hold = hold - 1;
      result_ready <= (hold == 0);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("[lif_neuron_layer_step_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // send one word after a random gap; valid stays up across back-to-back words
  task automatic send_item(input lif_pkg::item_t it);
    int gap;
    if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_word  <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    due_updates.push_back(integrate_neuron(it));
  endtask

  // hold off the sender until every predicted word has come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (due_updates.size() != 0) @(posedge clk);
  endtask

  // write both registers; only called with the block drained
  task automatic configure(input logic [lif_pkg::DECAY_W-1:0] decay,
                           input logic [lif_pkg::THR_W-1:0] thr);
    cfg_index <= lif_pkg::REG_DECAY;
    cfg_data  <= lif_pkg::CFG_W'(decay);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    decay_setting = decay;
    cfg_index <= lif_pkg::REG_THRESHOLD;
    cfg_data  <= lif_pkg::CFG_W'(thr);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thr_setting = thr;
    cfg_valid <= 1'b0;
  endtask

  // random mix: mostly a few hot neurons (same-neuron hazards, firing chains),
  // some full-range indexes, occasional clears
  task automatic send_random_items(input int count);
    lif_pkg::mode_t m;
    int    n;
    int    cur;
    for (int k = 0; k < count; k++) begin
      m = ($urandom_range(0, 15) == 0) ? lif_pkg::MODE_CLEAR : lif_pkg::MODE_INTEGRATE;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NEURONS - 1) : $urandom_range(0, 7);
      case ($urandom_range(0, 3))
        0:       cur = int'($urandom_range(0, 65535));
        1:       cur = $urandom_range(0, 1023);
        2:       cur = -int'($urandom_range(0, 512));
        default: cur = $urandom_range(0, 1) ? 32767 : -32768;
      endcase
      // pressure point: sender waits for a full drain now and then
      if (k % 97 == 50) wait_drained();
      send_item(make_item(m, n, cur));
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // reset settings: field extremes, fire on equality, delayed spike, clears
  task automatic test_directed_extremes();
    send_item(make_item(lif_pkg::MODE_INTEGRATE, 0, 32767));    // fires at once
    send_item(make_item(lif_pkg::MODE_INTEGRATE, 0, 0));        // shows the delayed spike
    send_item(make_item(lif_pkg::MODE_INTEGRATE, 0, -32768));
    send_item(make_item(lif_pkg::MODE_CLEAR, 0, 1234));         // current ignored on clear
    send_item(make_item(lif_pkg::MODE_INTEGRATE, 0, 0));
    send_item(make_item(lif_pkg::MODE_INTEGRATE, NEURONS - 1, 256));  // sum equals threshold
    send_item(make_item(lif_pkg::MODE_INTEGRATE, NEURONS - 1, 255));
    send_item(make_item(lif_pkg::MODE_INTEGRATE, NEURONS - 1, -1));
    send_item(make_item(lif_pkg::MODE_CLEAR, NEURONS - 1, 32767));
    send_item(make_item(lif_pkg::MODE_INTEGRATE, NEURONS - 1, -32768));
    send_item(make_item(lif_pkg::MODE_INTEGRATE, 4096, 'h5555));
    send_item(make_item(lif_pkg::MODE_INTEGRATE, 'h0aaa, 'haaaa));
    send_item(make_item(lif_pkg::MODE_INTEGRATE, 1, 1));
    send_item(make_item(lif_pkg::MODE_INTEGRATE, 2, 300));
    send_item(make_item(lif_pkg::MODE_INTEGRATE, 1, -1));
    send_item(make_item(lif_pkg::MODE_INTEGRATE, 2, 0));
    send_item(make_item(lif_pkg::MODE_CLEAR, 1, 0));
    send_item(make_item(lif_pkg::MODE_INTEGRATE, 1, 255));
    wait_drained();
  endtask

  // slowest leak, largest threshold: one neuron ramps up into the positive
  // clip (and fires there), the other ramps down and sits on the negative clip
  task automatic test_saturation_ramp();
    int n;
    configure('1, '1);
    send_item(make_item(lif_pkg::MODE_CLEAR, 20, 0));
    send_item(make_item(lif_pkg::MODE_CLEAR, 21, 0));
    for (int k = 0; k < 620; k++) begin
      n = 20 + $urandom_range(0, 1);
      if (n == 20)
        send_item(make_item(lif_pkg::MODE_INTEGRATE, n, $urandom_range(30000, 32767)));
      else
        send_item(make_item(lif_pkg::MODE_INTEGRATE, n,
                            -int'($urandom_range(30000, 32768))));
    end
    wait_drained();
  endtask

  // full leak and zero threshold: fires on any non-negative sum, no subtract
  task automatic test_zero_threshold();
    configure('0, '0);
    send_random_items(160);
    wait_drained();
  endtask

  task automatic test_random_traffic(input logic [lif_pkg::DECAY_W-1:0] decay,
                                     input logic [lif_pkg::THR_W-1:0] thr);
    configure(decay, thr);
    send_random_items(160);
    wait_drained();
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < NEURONS; i++) begin
      neuron_membrane[i] = '0;
      neuron_spike[i]    = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    test_saturation_ramp();
    test_zero_threshold();
    test_random_traffic(lif_pkg::DECAY_RESET, lif_pkg::THR_RESET);
    test_random_traffic(lif_pkg::DECAY_W'($urandom),
                        lif_pkg::THR_W'($urandom_range(1, 2048)));
    test_random_traffic(16'd32768, 23'd1);

    // let any late word show up before judging
    repeat (8) @(posedge clk);
    if (due_updates.size() != 0)
      report_mismatch("missing words", '0, 0, due_updates.size());
    if (mismatch_count == 0) begin
      $display("[lif_neuron_layer_step_unit] OK");
    end else begin
      $display("[lif_neuron_layer_step_unit] ERROR");
    end
    $finish;
  end

endmodule
